// ===== hw/rtl/ltu_pkg.sv =====
// Constants, zone codes and calendar helper functions for the local time to UTC converter.
// Has no dependencies. Used by local_time_to_utc_ns and ltu_checker.
`timescale 1ns / 1ps
`default_nettype none

package ltu_pkg;

   // zone selector codes carried on req_tuser
   localparam logic [1:0] ZONE_NEW_YORK = 2'd0;
   localparam logic [1:0] ZONE_CHICAGO  = 2'd1;

   // bit positions in rsp_tuser
   localparam int RSP_DST_BIT = 0;
   localparam int RSP_ERR_BIT = 1;

   // zone offsets in seconds, local to UTC
   localparam logic [17:0] OFF_NY_STD  = 18'd18000;   // 5 h
   localparam logic [17:0] OFF_NY_DST  = 18'd14400;   // 4 h
   localparam logic [17:0] OFF_CHI_STD = 18'd21600;   // 6 h
   localparam logic [17:0] OFF_CHI_DST = 18'd18000;   // 5 h

   // day count of 0000-03-01 relative to 1970-01-01, negated
   localparam logic signed [21:0] EPOCH_DAYS  = 22'sd719468;
   localparam logic signed [38:0] SEC_PER_DAY = 39'sd86400;

   // reciprocals: x/100 = (x*5243)>>19 for x < 43699, x/7 = (x*9363)>>16 for x < 8192
   localparam logic [24:0] RECIP_100 = 25'd5243;
   localparam logic [25:0] RECIP_7   = 26'd9363;

   localparam logic [33:0] MAX_SEC    = 34'd9223372036;
   localparam logic [46:0] NS_PER_SEC = 47'd1000000000;

   // first day of the month relative to 1 March, leap day not included
   function automatic logic signed [9:0] month_base(input logic [3:0] mc);
      logic signed [9:0] b;
      case (mc)
         4'd1:    b = -10'sd59;
         4'd2:    b = -10'sd28;
         4'd3:    b = 10'sd0;
         4'd4:    b = 10'sd31;
         4'd5:    b = 10'sd61;
         4'd6:    b = 10'sd92;
         4'd7:    b = 10'sd122;
         4'd8:    b = 10'sd153;
         4'd9:    b = 10'sd184;
         4'd10:   b = 10'sd214;
         4'd11:   b = 10'sd245;
         4'd12:   b = 10'sd275;
         default: b = 10'sd0;
      endcase
      return b;
   endfunction

   // days from a weekday (0 is Sunday) to the next Sunday, zero if already Sunday
   function automatic logic [2:0] sunday_delta(input logic [2:0] w);
      logic [2:0] d;
      case (w)
         3'd0:    d = 3'd0;
         3'd1:    d = 3'd6;
         3'd2:    d = 3'd5;
         3'd3:    d = 3'd4;
         3'd4:    d = 3'd3;
         3'd5:    d = 3'd2;
         3'd6:    d = 3'd1;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/local_time_to_utc_ns.sv =====
// Local civil date and time in New York or Chicago to UTC nanoseconds, with US daylight time.
// Depends on ltu_pkg.
//
//   channel  dir  payload
//   req_     in   tdata: year, month, day, hour, minute, second; tuser: zone code
//   rsp_     out  tdata: utc_ns; tuser: dst_on, zone_error
//
// Eight register stages, the input register through the result register; one request per
// cycle unless the pipeline is full and rsp_ is stalled. Stage 6 holds two constant multiplies
// (17 by 30 bits each, for the nanosecond scaling). Each stage holds its request while the
// next is full, so empty stages fill while rsp_ is stalled. Reset clears the stage valid
// bits only.
`timescale 1ns / 1ps
`default_nettype none

module local_time_to_utc_ns
   import ltu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [11:0] local_year, [15:12] local_month, [20:16] day_of_month, [25:21] local_hour,
   // [31:26] local_minute, [37:32] local_second, [39:38] zero
   input  wire logic [39:0] req_tdata,
   // [1:0] zone_code
   input  wire logic [1:0]  req_tuser,

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [62:0] utc_ns, [63] zero
   output      logic [63:0] rsp_tdata,
   // [0] dst_on, [1] zone_error
   output      logic [1:0]  rsp_tuser
);

   localparam int NUM_STAGES = 8;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] en;

   // stage 0: input register
   logic [11:0] s0_year_ff;
   logic [3:0]  s0_month_ff;
   logic [4:0]  s0_day_ff;
   logic [4:0]  s0_hour_ff;
   logic [5:0]  s0_minute_ff;
   logic [5:0]  s0_second_ff;
   logic [1:0]  s0_zone_ff;

   // stage 1
   logic [24:0] q100_prod;
   logic [5:0]  s1_q100_in, s1_q100_ff;
   logic [20:0] s1_y365_in, s1_y365_ff;
   logic [3:0]  s1_month_in, s1_month_ff;
   logic [16:0] s1_tod_in, s1_tod_ff;
   logic        s1_err_in, s1_err_ff;
   logic [11:0] s1_year_ff;
   logic [4:0]  s1_day_ff;
   logic [1:0]  s1_zone_ff;

   // stage 2
   logic [6:0]         rem100;
   logic               leap;
   logic signed [21:0] s2_d3_in, s2_d3_ff;
   logic [12:0]        s2_wsum_in, s2_wsum_ff;
   logic signed [9:0]  s2_r_in, s2_r_ff;
   logic [16:0]        s2_tod_ff;
   logic [1:0]         s2_zone_ff;
   logic               s2_err_ff;

   // stage 3
   logic [25:0]        q7_prod;
   logic [9:0]         s3_q7_in, s3_q7_ff;
   logic signed [21:0] s3_days_in, s3_days_ff;
   logic [12:0]        s3_wsum_ff;
   logic signed [9:0]  s3_r_ff;
   logic [16:0]        s3_tod_ff;
   logic [1:0]         s3_zone_ff;
   logic               s3_err_ff;

   // stage 4
   logic [12:0]        wrem;
   logic [2:0]         delta;
   logic signed [9:0]  dst_lo, dst_hi;
   logic [17:0]        offset;
   logic               s4_dst_in, s4_dst_ff;
   logic signed [38:0] s4_dsec_in, s4_dsec_ff;
   logic [17:0]        s4_toff_in, s4_toff_ff;
   logic               s4_err_ff;

   // stage 5
   logic signed [38:0] sec_sum;
   logic [33:0]        s5_sec_ff;
   logic               s5_zero_in, s5_zero_ff;
   logic               s5_sat_in, s5_sat_ff;
   logic               s5_dst_ff;
   logic               s5_err_ff;

   // stage 6
   logic [46:0] s6_phi_in, s6_phi_ff;
   logic [46:0] s6_plo_in, s6_plo_ff;
   logic        s6_zero_ff, s6_sat_ff, s6_dst_ff, s6_err_ff;

   // stage 7: result register
   logic [63:0] ns_sum;
   logic [62:0] s7_ns_in, s7_ns_ff;
   logic        s7_dst_ff, s7_err_ff;

   // stall chain: a stage loads when it is empty or the next one loads
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // stage 1: year/100, 365*year, clamped month, time of day
   always_comb begin
      q100_prod   = 25'(s0_year_ff) * RECIP_100;
      s1_q100_in  = q100_prod[24:19];
      s1_y365_in  = 21'(s0_year_ff) * 21'd365;
      if (s0_month_ff == 4'd0) begin
         s1_month_in = 4'd1;
      end else if (s0_month_ff > 4'd12) begin
         s1_month_in = 4'd12;
      end else begin
         s1_month_in = s0_month_ff;
      end
      s1_tod_in = 17'(s0_hour_ff) * 17'd3600 + 17'(s0_minute_ff) * 17'd60
                + 17'(s0_second_ff);
      s1_err_in = (s0_zone_ff != ZONE_NEW_YORK) && (s0_zone_ff != ZONE_CHICAGO);
   end

   // stage 2: day count of 1 March, weekday sum, day offset from 1 March
   always_comb begin
      rem100 = 7'(s1_year_ff - 12'(s1_q100_ff) * 12'd100);
      leap   = (s1_year_ff[1:0] == 2'd0) && ((rem100 != 7'd0) || (s1_q100_ff[1:0] == 2'd0));
      s2_d3_in = $signed({1'b0, s1_y365_ff}) + $signed(22'(s1_year_ff[11:2]))
               - $signed(22'(s1_q100_ff)) + $signed(22'(s1_q100_ff[5:2])) - EPOCH_DAYS;
      s2_wsum_in = 13'(s1_year_ff) + 13'(s1_year_ff[11:2]) - 13'(s1_q100_ff)
                 + 13'(s1_q100_ff[5:2]) + 13'd3;
      s2_r_in = month_base(s1_month_ff) + $signed(10'(s1_day_ff)) - 10'sd1
              - ((leap && (s1_month_ff <= 4'd2)) ? 10'sd1 : 10'sd0);
   end

   // stage 3: wsum/7, absolute day count
   always_comb begin
      q7_prod    = 26'(s2_wsum_ff) * RECIP_7;
      s3_q7_in   = q7_prod[25:16];
      s3_days_in = s2_d3_ff + 22'(s2_r_ff);
   end

   // stage 4: weekday of 1 March (1 November falls on the same one), daylight window, offset
   always_comb begin
      wrem   = s3_wsum_ff - 13'(s3_q7_ff) * 13'd7;
      delta  = sunday_delta(wrem[2:0]);
      dst_lo = $signed(10'(delta)) + 10'sd7;
      dst_hi = $signed(10'(delta)) + 10'sd245;
      s4_dst_in = !s3_err_ff && (s3_r_ff >= dst_lo) && (s3_r_ff < dst_hi);
      if (s3_zone_ff == ZONE_NEW_YORK) begin
         offset = s4_dst_in ? OFF_NY_DST : OFF_NY_STD;
      end else begin
         offset = s4_dst_in ? OFF_CHI_DST : OFF_CHI_STD;
      end
      s4_toff_in = 18'(s3_tod_ff) + offset;
      s4_dsec_in = 39'(s3_days_ff) * SEC_PER_DAY;
   end

   // stage 5: seconds since the epoch and clipping
   always_comb begin
      sec_sum    = s4_dsec_ff + $signed(39'(s4_toff_ff));
      s5_zero_in = s4_err_ff || (sec_sum <= 39'sd0);
      s5_sat_in  = sec_sum > $signed(39'(MAX_SEC));
   end

   // stage 6: nanoseconds as two partial products
   always_comb begin
      s6_phi_in = 47'(s5_sec_ff[33:17]) * NS_PER_SEC;
      s6_plo_in = 47'(s5_sec_ff[16:0]) * NS_PER_SEC;
   end

   // stage 7
   always_comb begin
      ns_sum = {s6_phi_ff[46:0], 17'd0} + 64'(s6_plo_ff);
      if (s6_zero_ff) begin
         s7_ns_in = '0;
      end else if (s6_sat_ff) begin
         s7_ns_in = '1;
      end else begin
         s7_ns_in = ns_sum[62:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_year_ff   <= req_tdata[11:0];
         s0_month_ff  <= req_tdata[15:12];
         s0_day_ff    <= req_tdata[20:16];
         s0_hour_ff   <= req_tdata[25:21];
         s0_minute_ff <= req_tdata[31:26];
         s0_second_ff <= req_tdata[37:32];
         s0_zone_ff   <= req_tuser;
      end
      if (en[1]) begin
         s1_q100_ff  <= s1_q100_in;
         s1_y365_ff  <= s1_y365_in;
         s1_month_ff <= s1_month_in;
         s1_tod_ff   <= s1_tod_in;
         s1_err_ff   <= s1_err_in;
         s1_year_ff  <= s0_year_ff;
         s1_day_ff   <= s0_day_ff;
         s1_zone_ff  <= s0_zone_ff;
      end
      if (en[2]) begin
         s2_d3_ff   <= s2_d3_in;
         s2_wsum_ff <= s2_wsum_in;
         s2_r_ff    <= s2_r_in;
         s2_tod_ff  <= s1_tod_ff;
         s2_zone_ff <= s1_zone_ff;
         s2_err_ff  <= s1_err_ff;
      end
      if (en[3]) begin
         s3_q7_ff   <= s3_q7_in;
         s3_days_ff <= s3_days_in;
         s3_wsum_ff <= s2_wsum_ff;
         s3_r_ff    <= s2_r_ff;
         s3_tod_ff  <= s2_tod_ff;
         s3_zone_ff <= s2_zone_ff;
         s3_err_ff  <= s2_err_ff;
      end
      if (en[4]) begin
         s4_dst_ff  <= s4_dst_in;
         s4_dsec_ff <= s4_dsec_in;
         s4_toff_ff <= s4_toff_in;
         s4_err_ff  <= s3_err_ff;
      end
      if (en[5]) begin
         s5_sec_ff  <= sec_sum[33:0];
         s5_zero_ff <= s5_zero_in;
         s5_sat_ff  <= s5_sat_in;
         s5_dst_ff  <= s4_dst_ff;
         s5_err_ff  <= s4_err_ff;
      end
      if (en[6]) begin
         s6_phi_ff  <= s6_phi_in;
         s6_plo_ff  <= s6_plo_in;
         s6_zero_ff <= s5_zero_ff;
         s6_sat_ff  <= s5_sat_ff && !s5_zero_ff;
         s6_dst_ff  <= s5_dst_ff;
         s6_err_ff  <= s5_err_ff;
      end
      if (en[7]) begin
         s7_ns_ff  <= s7_ns_in;
         s7_dst_ff <= s6_dst_ff;
         s7_err_ff <= s6_err_ff;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {1'b0, s7_ns_ff};
   assign rsp_tuser  = {s7_err_ff, s7_dst_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/ltu_checker.sv =====
// Port-level checks for local_time_to_utc_ns, attached by the bind at the end of this file.
// Depends on ltu_pkg and on the port names of local_time_to_utc_ns.
`timescale 1ns / 1ps
`default_nettype none

module ltu_checker
   import ltu_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_zone_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_ERR_BIT] |-> (rsp_tdata == 64'd0) && !rsp_tuser[RSP_DST_BIT])
      else $error("zone error with non-zero time or daylight flag");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request refused while the result side drains");

   // ready is checked for unknown values after each accepted request
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$isunknown(req_tready))
      else $error("request ready unknown after an accepted request");

endmodule

bind local_time_to_utc_ns ltu_checker u_ltu_checker (.*);

`default_nettype wire
